### design/mant_pkg.sv
// ----------------------------------------------------------------------------
// mant_pkg
// Shared types, codes and defaults for the MIDI active note tracker.
// ----------------------------------------------------------------------------
package mant_pkg;

  // Default sizes of the tracker
  localparam int NUM_SOURCES_DEF  = 3;
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int NUM_NOTES_DEF    = 128;
  localparam int MAX_LIST_DEF     = 64;

  // Bitmap rows: two 64-bit rows per source and channel
  localparam int ROW_BITS      = 64;
  localparam int ROWS_PER_SLOT = 2;

  // Function codes
  localparam logic [1:0] FUNC_EVENT   = 2'd0;
  localparam logic [1:0] FUNC_QUERY   = 2'd1;
  localparam logic [1:0] FUNC_COLLECT = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  // Event kinds
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_CC       = 2'd2;
  localparam logic [1:0] KIND_OTHER    = 2'd3;

  // Channel mode controllers that drop every note of a channel
  localparam logic [7:0] CC_SOUND_OFF = 8'd120;
  localparam logic [7:0] CC_NOTES_OFF = 8'd123;

  // Saturation point of the active count
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_LOAD1,
    ST_FLUSH
  } state_t;

  // One input word
  typedef struct packed {
    logic [1:0] func;
    logic [1:0] source;
    logic [3:0] channel;
    logic [1:0] event_kind;
    logic [7:0] note_or_controller;
    logic [6:0] velocity;
    logic [6:0] list_cap;
  } item_t;

  // One result word
  typedef struct packed {
    logic [6:0] active_count;
    logic       note_active;
    logic [6:0] listed_note;
    logic       listed_valid;
    logic [6:0] listed_total;
    logic       ignored;
    logic       last;
  } result_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;      // latch the word, read row and count
    logic fire_single;  // commit a single-result item and load its result
    logic scan_load0;   // load the low row into the scanner, read the high row
    logic scan_load1;   // load the high row into the scanner
    logic scan_step;    // advance the scanner by one note
    logic take_note;    // hold the current note as pending
    logic push_pend;    // send the pending note
    logic push_last;    // mark the sent pending note as final
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       addr_ok;
    logic       cap_zero;
    logic       cur_bit;
    logic       pend_valid;
    logic       cap_hit;
    logic       scan_end;
    logic       row_end;
    logic       out_free;
  } sts_t;

endpackage

### design/mant_if.sv
// ----------------------------------------------------------------------------
// mant_if
// Request and response channels of the MIDI active note tracker.
// ----------------------------------------------------------------------------
interface mant_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] src;
  logic [3:0] channel;
  logic [1:0] event_kind;
  logic [7:0] note_or_controller;
  logic [6:0] velocity;
  logic [6:0] list_cap;

  modport source (
    output valid, func, src, channel, event_kind, note_or_controller, velocity,
           list_cap,
    input  ready
  );
  modport sink (
    input  valid, func, src, channel, event_kind, note_or_controller, velocity,
           list_cap,
    output ready
  );
endinterface

interface mant_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] active_count;
  logic       note_active;
  logic [6:0] listed_note;
  logic       listed_valid;
  logic [6:0] listed_total;
  logic       ignored;
  logic       last;

  modport source (
    output valid, active_count, note_active, listed_note, listed_valid, listed_total,
           ignored, last,
    input  ready
  );
  modport sink (
    input  valid, active_count, note_active, listed_note, listed_valid, listed_total,
           ignored, last,
    output ready
  );
endinterface

### design/midi_active_note_tracker.sv
// ----------------------------------------------------------------------------
// midi_active_note_tracker
// Held-note bitmaps and active counts per MIDI source and channel.
// ----------------------------------------------------------------------------
// Usage: words arrive on req (valid/ready) and results leave on rsp
// (valid/ready). A word is taken only while the block is free; req.ready
// drops for the cycles the word is at work.
// Event, query and clear-all words give one result, loaded into the output
// register once the word is executed and the output register is free; the
// next word is taken only after that. These go through one registered read
// of the row and count stores; valid note-on and note-off events write them.
// Collect walks the channel's bitmap one note per cycle, pausing to load
// the high row and while a found note waits on a full output register,
// and ends early when list_cap notes are found. Each found note is sent
// when the next is found or the walk ends, so last is exact.
// Reset (and clear-all) wipe the stores by clearing per-entry
// valid bits; no clearing pass. A stalled receiver holds the output
// register; the block takes the next word meanwhile and waits only when it
// has a new result to send.
// ----------------------------------------------------------------------------
module midi_active_note_tracker
  import mant_pkg::*;
#(
  parameter int NUM_SOURCES  = NUM_SOURCES_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_NOTES    = NUM_NOTES_DEF,
  parameter int MAX_LIST     = MAX_LIST_DEF
) (
  input logic      clk,
  input logic      rst,
  mant_req_if.sink req,
  mant_rsp_if.source rsp
);

  item_t   item;
  cmd_t    cmd;
  sts_t    sts;
  result_t res;
  logic    res_valid;
  logic    in_ready;

  // Gather the request word
  assign item.func               = req.func;
  assign item.source             = req.src;
  assign item.channel            = req.channel;
  assign item.event_kind         = req.event_kind;
  assign item.note_or_controller = req.note_or_controller;
  assign item.velocity           = req.velocity;
  assign item.list_cap           = req.list_cap;
  assign req.ready               = in_ready;

  mant_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mant_dp #(
    .NUM_SOURCES  (NUM_SOURCES),
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_NOTES    (NUM_NOTES),
    .MAX_LIST     (MAX_LIST)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (rsp.ready)
  );

  // Drive the response word
  assign rsp.valid        = res_valid;
  assign rsp.active_count = res.active_count;
  assign rsp.note_active  = res.note_active;
  assign rsp.listed_note  = res.listed_note;
  assign rsp.listed_valid = res.listed_valid;
  assign rsp.listed_total = res.listed_total;
  assign rsp.ignored      = res.ignored;
  assign rsp.last         = res.last;

`ifndef SYNTHESIS
  // A taken word keeps the block busy for at least the next cycle
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken on two consecutive cycles");

  // A listed note is held and counted
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.listed_valid |-> rsp.note_active && (rsp.listed_total != 7'd0))
    else $error("listed note without held bit or total");

  // Dropped words give one plain final result
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ignored |-> rsp.last && !rsp.listed_valid && !rsp.note_active)
    else $error("ignored result carries note data");

  // The list never runs past its cap
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (32'(rsp.listed_total) <= MAX_LIST))
    else $error("listed total above cap");
`endif

endmodule

### design/mant_dp.sv
// ----------------------------------------------------------------------------
// mant_dp
// Datapath: bitmap and count stores, event update, note scanner, result register.
// ----------------------------------------------------------------------------
module mant_dp
  import mant_pkg::*;
#(
  parameter int NUM_SOURCES  = NUM_SOURCES_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_NOTES    = NUM_NOTES_DEF,
  parameter int MAX_LIST     = MAX_LIST_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output sts_t    sts,
  output result_t res,
  output logic    res_valid,
  input  logic    res_ready
);

  localparam int SLOTS  = NUM_SOURCES * NUM_CHANNELS;
  localparam int ROWS   = SLOTS * ROWS_PER_SLOT;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ROW_W  = SLOT_W + 1;

  // Stores and their valid bits
  logic [ROW_BITS-1:0] row_mem [ROWS];
  logic [6:0]          cnt_mem [SLOTS];
  logic [ROWS-1:0]     row_vld;
  logic [SLOTS-1:0]    cnt_vld;

  // Read registers
  logic [ROW_BITS-1:0] row_q;
  logic                row_vld_q;
  logic [6:0]          cnt_q;
  logic                cnt_vld_q;

  // Latched item
  item_t               item_q;
  logic                addr_ok_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [6:0]          cap_q;

  // Scanner
  logic [ROW_BITS-1:0] scan_row;
  logic [6:0]          nt;
  logic [6:0]          n;
  logic                pend_valid;
  logic [6:0]          pend_note;
  logic [6:0]          pend_total;

  // Decode of the incoming word
  logic                in_addr_ok;
  logic [SLOT_W-1:0]   in_slot;
  logic                in_hi;
  logic [6:0]          in_cap;
  logic [ROW_W-1:0]    rd_addr;
  logic                rd_en;

  // Update logic
  logic [ROW_BITS-1:0] row_cur;
  logic [ROW_BITS-1:0] row_new;
  logic [ROW_BITS-1:0] mask;
  logic [6:0]          cnt_cur;
  logic [6:0]          cnt_new;
  logic                note_ok;
  logic                bit_was;
  logic                set_op;
  logic                is_off_cc;
  logic                ev_write;
  logic                cc_clear;
  logic                clr_all;
  logic [ROW_W-1:0]    wr_addr;
  result_t             single_res;
  result_t             push_res;
  logic                res_load;

  // Decode source and channel into a slot
  assign in_addr_ok = (32'(item.source) < NUM_SOURCES) && (32'(item.channel) < NUM_CHANNELS);
  assign in_slot    = in_addr_ok ?
                      SLOT_W'(32'(item.source) * NUM_CHANNELS + 32'(item.channel)) : '0;
  assign in_hi      = (item.func == FUNC_COLLECT) ? 1'b0 : item.note_or_controller[6];
  assign in_cap     = (32'(item.list_cap) > MAX_LIST) ? 7'(MAX_LIST) : item.list_cap;

  assign rd_en   = cmd.capture || cmd.scan_load0;
  assign rd_addr = cmd.scan_load0 ? {slot_q, 1'b1} : {in_slot, in_hi};

  // Latch the word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q    <= item;
      addr_ok_q <= in_addr_ok;
      slot_q    <= in_slot;
      cap_q     <= in_cap;
    end
  end

  // Registered reads of row and count
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_q     <= row_mem[rd_addr];
      row_vld_q <= row_vld[rd_addr];
    end
    if (cmd.capture) begin
      cnt_q     <= cnt_mem[in_slot];
      cnt_vld_q <= cnt_vld[in_slot];
    end
  end

  // Event update of the addressed note
  assign row_cur   = row_vld_q ? row_q : '0;
  assign cnt_cur   = cnt_vld_q ? cnt_q : '0;
  assign note_ok   = 32'(item_q.note_or_controller) < NUM_NOTES;
  assign mask      = ROW_BITS'(1) << item_q.note_or_controller[5:0];
  assign bit_was   = row_cur[item_q.note_or_controller[5:0]];
  assign set_op    = (item_q.event_kind == KIND_NOTE_ON) && (item_q.velocity != 7'd0);
  assign is_off_cc = (item_q.note_or_controller == CC_SOUND_OFF) ||
                     (item_q.note_or_controller == CC_NOTES_OFF);
  assign row_new   = set_op ? (row_cur | mask) : (row_cur & ~mask);

  always_comb begin
    cnt_new = cnt_cur;
    if (set_op) begin
      if (!bit_was && (cnt_cur < COUNT_MAX)) cnt_new = cnt_cur + 7'd1;
    end else begin
      if (bit_was && (cnt_cur != 7'd0)) cnt_new = cnt_cur - 7'd1;
    end
  end

  assign ev_write = cmd.fire_single && (item_q.func == FUNC_EVENT) && addr_ok_q && note_ok &&
                    ((item_q.event_kind == KIND_NOTE_ON) || (item_q.event_kind == KIND_NOTE_OFF));
  assign cc_clear = cmd.fire_single && (item_q.func == FUNC_EVENT) && addr_ok_q &&
                    (item_q.event_kind == KIND_CC) && is_off_cc;
  assign clr_all  = cmd.fire_single && (item_q.func == FUNC_CLEAR);
  assign wr_addr  = {slot_q, item_q.note_or_controller[6]};

  // Write the stores
  always_ff @(posedge clk) begin
    if (ev_write) begin
      row_mem[wr_addr] <= row_new;
      cnt_mem[slot_q]  <= cnt_new;
    end
  end

  // Track which entries hold written data
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      row_vld <= '0;
      cnt_vld <= '0;
    end else begin
      if (ev_write) begin
        row_vld[wr_addr] <= 1'b1;
        cnt_vld[slot_q]  <= 1'b1;
      end
      if (cc_clear) begin
        row_vld[{slot_q, 1'b0}] <= 1'b0;
        row_vld[{slot_q, 1'b1}] <= 1'b0;
        cnt_vld[slot_q]         <= 1'b0;
      end
    end
  end

  // Walk the row one note per cycle while the controller steps the scanner, hold the latest found note as pending
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.scan_load0) begin
      pend_valid <= 1'b0;
    end else if (cmd.take_note) begin
      pend_valid <= 1'b1;
    end else if (cmd.push_pend) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_load0) begin
      scan_row <= row_cur;
      nt       <= 7'd0;
      n        <= 7'd0;
    end else begin
      if (cmd.scan_load1) scan_row <= row_cur;
      if (cmd.scan_step) begin
        scan_row <= scan_row >> 1;
        nt       <= nt + 7'd1;
      end
      if (cmd.take_note) begin
        pend_note  <= nt;
        pend_total <= n + 7'd1;
        n          <= n + 7'd1;
      end
    end
  end

  // Result of a single-result item, also the empty collect
  always_comb begin
    single_res              = '0;
    single_res.last         = 1'b1;
    if (item_q.func != FUNC_CLEAR) begin
      if (!addr_ok_q) begin
        single_res.ignored = 1'b1;
      end else begin
        case (item_q.func)
          FUNC_EVENT: begin
            case (item_q.event_kind)
              KIND_CC:    single_res.active_count = is_off_cc ? 7'd0 : cnt_cur;
              KIND_OTHER: single_res.active_count = cnt_cur;
              default: begin
                if (!note_ok) begin
                  single_res.active_count = cnt_cur;
                  single_res.ignored      = 1'b1;
                end else begin
                  single_res.active_count = cnt_new;
                  single_res.note_active  = set_op;
                end
              end
            endcase
          end
          FUNC_QUERY: begin
            single_res.active_count = cnt_cur;
            single_res.note_active  = note_ok && bit_was;
            single_res.ignored      = !note_ok;
          end
          default: single_res.active_count = cnt_cur;
        endcase
      end
    end
  end

  // Result of a listed note
  always_comb begin
    push_res              = '0;
    push_res.active_count = cnt_cur;
    push_res.note_active  = 1'b1;
    push_res.listed_note  = pend_note;
    push_res.listed_valid = 1'b1;
    push_res.listed_total = pend_total;
    push_res.last         = cmd.push_last;
  end

  // Output register: hold until taken
  assign res_load = cmd.fire_single || cmd.push_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res <= cmd.fire_single ? single_res : push_res;
  end

  // Status to the controller
  assign sts.func       = item_q.func;
  assign sts.addr_ok    = addr_ok_q;
  assign sts.cap_zero   = (cap_q == 7'd0);
  assign sts.cur_bit    = scan_row[0];
  assign sts.pend_valid = pend_valid;
  assign sts.cap_hit    = ((n + 7'd1) == cap_q);
  assign sts.scan_end   = (nt == 7'(NUM_NOTES - 1));
  assign sts.row_end    = (nt[5:0] == 6'd63);
  assign sts.out_free   = !res_valid || res_ready;

endmodule

### design/mant_ctrl.sv
// ----------------------------------------------------------------------------
// mant_ctrl
// Controller: sequences capture, update, note scan and result hand-off.
// ----------------------------------------------------------------------------
module mant_ctrl
  import mant_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((sts.func == FUNC_COLLECT) && sts.addr_ok && !sts.cap_zero) begin
          cmd.scan_load0 = 1'b1;
          state_next     = ST_SCAN;
        end else if (sts.out_free) begin
          cmd.fire_single = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Stall when a found note must push the pending one and the output is full
        if (!(sts.cur_bit && sts.pend_valid && !sts.out_free)) begin
          if (sts.cur_bit) begin
            cmd.take_note = 1'b1;
            cmd.push_pend = sts.pend_valid;
          end
          if (sts.cur_bit && sts.cap_hit) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end) begin
              state_next = ST_FLUSH;
            end else if (sts.row_end) begin
              state_next = ST_LOAD1;
            end
          end
        end
      end
      ST_LOAD1: begin
        cmd.scan_load1 = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          if (sts.pend_valid) begin
            cmd.push_pend = 1'b1;
            cmd.push_last = 1'b1;
          end else begin
            cmd.fire_single = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
